>>> rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int ByteW  = 8;
    localparam int KindW  = 4;
    localparam int PosW   = 17;
    localparam int LenW   = 16;
    localparam int CfgIdxW = 2;

    // frame positions of the fixed fields
    localparam logic [PosW-1:0] PosSync1   = PosW'(0);
    localparam logic [PosW-1:0] PosSync2   = PosW'(1);
    localparam logic [PosW-1:0] PosLenHi   = PosW'(6);
    localparam logic [PosW-1:0] PosLenLo   = PosW'(7);
    localparam logic [PosW-1:0] PosPayload = PosW'(8);

    // register reset values
    localparam logic [ByteW-1:0] SyncFirstRst   = 8'd170;
    localparam logic [ByteW-1:0] SyncSecondRst  = 8'd85;
    localparam logic [LenW-1:0]  PayloadLimRst  = 16'd256;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_PAYLOAD_LIM = 2'd2
    } t_cfg_idx;

    typedef enum logic [KindW-1:0] {
        KIND_SKIP     = 4'd0,
        KIND_SYNC1    = 4'd1,
        KIND_SYNC2    = 4'd2,
        KIND_HEADER   = 4'd3,
        KIND_LEN_HI   = 4'd4,
        KIND_LEN_LO   = 4'd5,
        KIND_PAYLOAD  = 4'd6,
        KIND_CRC_LO   = 4'd7,
        KIND_CRC_HI   = 4'd8,
        KIND_BAD_SYNC = 4'd9,
        KIND_TOO_LONG = 4'd10
    } t_kind;

    typedef struct packed {
        logic [ByteW-1:0] sync_first;
        logic [ByteW-1:0] sync_second;
        logic [LenW-1:0]  payload_limit;
    } t_cfg;

    typedef struct packed {
        logic [ByteW-1:0] echo_byte;
        t_kind            byte_kind;
        logic [PosW-1:0]  frame_offset;
        logic [LenW-1:0]  payload_count;
        logic             frame_end;
    } t_result;

endpackage

>>> rtl/lpfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpfd_cfg_regs
// Configuration registers: sync byte values and the payload length limit.
// ----------------------------------------------------------------------------
module lpfd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lpfd_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [lpfd_pkg::LenW-1:0]       i_cfg_data,
    output lpfd_pkg::t_cfg                  o_cfg
);

    lpfd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first    <= lpfd_pkg::SyncFirstRst;
            r_cfg.sync_second   <= lpfd_pkg::SyncSecondRst;
            r_cfg.payload_limit <= lpfd_pkg::PayloadLimRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lpfd_pkg::CFG_SYNC_FIRST: begin
                    r_cfg.sync_first <= i_cfg_data[lpfd_pkg::ByteW-1:0];
                end
                lpfd_pkg::CFG_SYNC_SECOND: begin
                    r_cfg.sync_second <= i_cfg_data[lpfd_pkg::ByteW-1:0];
                end
                lpfd_pkg::CFG_PAYLOAD_LIM: begin
                    r_cfg.payload_limit <= i_cfg_data;
                end
                default: begin
                    // unused index, write ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/lpfd_frame_track.sv
// ----------------------------------------------------------------------------
// lpfd_frame_track
// Frame position tracker: tags one byte per step and updates the frame position.
// ----------------------------------------------------------------------------
module lpfd_frame_track (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [lpfd_pkg::ByteW-1:0]    i_byte,
    input  lpfd_pkg::t_cfg                i_cfg,
    output lpfd_pkg::t_result             o_result
);

    logic [lpfd_pkg::PosW-1:0]  r_pos;
    logic [lpfd_pkg::LenW-1:0]  r_len;
    logic [lpfd_pkg::ByteW-1:0] r_len_hi;

    logic [lpfd_pkg::PosW-1:0]  n_pos;
    logic [lpfd_pkg::LenW-1:0]  n_len;
    logic [lpfd_pkg::ByteW-1:0] n_len_hi;

    logic [lpfd_pkg::LenW-1:0]  rx_len;
    logic [lpfd_pkg::PosW-1:0]  crc_lo_pos;
    lpfd_pkg::t_kind            kind;
    logic [lpfd_pkg::LenW-1:0]  count;
    logic                       last;

    assign rx_len     = {r_len_hi, i_byte};
    assign crc_lo_pos = lpfd_pkg::PosPayload + {1'b0, r_len};

    always_comb begin
        kind     = lpfd_pkg::KIND_SKIP;
        count    = '0;
        last     = 1'b0;
        n_pos    = r_pos;
        n_len    = r_len;
        n_len_hi = r_len_hi;
        if (r_pos == lpfd_pkg::PosSync1) begin
            if (i_byte == i_cfg.sync_first) begin
                kind  = lpfd_pkg::KIND_SYNC1;
                n_pos = lpfd_pkg::PosSync2;
            end
        end else if (r_pos == lpfd_pkg::PosSync2) begin
            // a wrong second sync byte is not retried as a first one
            if (i_byte == i_cfg.sync_second) begin
                kind  = lpfd_pkg::KIND_SYNC2;
                n_pos = r_pos + 1'b1;
            end else begin
                kind  = lpfd_pkg::KIND_BAD_SYNC;
                n_pos = lpfd_pkg::PosSync1;
            end
        end else if (r_pos < lpfd_pkg::PosLenHi) begin
            kind  = lpfd_pkg::KIND_HEADER;
            n_pos = r_pos + 1'b1;
        end else if (r_pos == lpfd_pkg::PosLenHi) begin
            kind     = lpfd_pkg::KIND_LEN_HI;
            n_len_hi = i_byte;
            n_pos    = r_pos + 1'b1;
        end else if (r_pos == lpfd_pkg::PosLenLo) begin
            // length is kept even when the frame is dropped
            n_len = rx_len;
            count = rx_len;
            if (rx_len > i_cfg.payload_limit) begin
                kind  = lpfd_pkg::KIND_TOO_LONG;
                n_pos = lpfd_pkg::PosSync1;
            end else begin
                kind  = lpfd_pkg::KIND_LEN_LO;
                n_pos = lpfd_pkg::PosPayload;
            end
        end else begin
            count = r_len;
            if (r_pos < crc_lo_pos) begin
                kind  = lpfd_pkg::KIND_PAYLOAD;
                n_pos = r_pos + 1'b1;
            end else if (r_pos == crc_lo_pos) begin
                kind  = lpfd_pkg::KIND_CRC_LO;
                n_pos = r_pos + 1'b1;
            end else begin
                kind  = lpfd_pkg::KIND_CRC_HI;
                last  = 1'b1;
                n_pos = lpfd_pkg::PosSync1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_len_hi <= '0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_len_hi <= n_len_hi;
        end
    end

    assign o_result.echo_byte     = i_byte;
    assign o_result.byte_kind     = kind;
    assign o_result.frame_offset  = r_pos;
    assign o_result.payload_count = count;
    assign o_result.frame_end     = last;

endmodule

>>> rtl/length_prefixed_frame_deframer_unit.sv
// a byte request passes the input register and then the result register to the
// output; throughput: one byte per cycle while the output does not stall; the
// separate input and result stages let one byte be taken while a result waits
// reset: synchronous active-low; clears pipeline valids and frame position,
// and loads the sync and limit registers with their default values
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_unit
// Byte-stream deframer: sync hunt, header, length, payload and crc tagging.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [lpfd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [lpfd_pkg::LenW-1:0]     i_cfg_data,
    // byte input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lpfd_pkg::ByteW-1:0]    i_rx_byte,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lpfd_pkg::ByteW-1:0]    o_echo_byte,
    output logic [lpfd_pkg::KindW-1:0]    o_byte_kind,
    output logic [lpfd_pkg::PosW-1:0]     o_frame_offset,
    output logic [lpfd_pkg::LenW-1:0]     o_payload_count,
    output logic                          o_frame_end
);

    lpfd_pkg::t_cfg             cfg;
    lpfd_pkg::t_result          result;

    logic                       r_in_valid;
    logic [lpfd_pkg::ByteW-1:0] r_in_byte;
    logic                       r_out_valid;
    lpfd_pkg::t_result          r_out;

    logic                       advance;
    logic                       step;
    logic                       in_accept;

    // result register free, or being emptied this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = advance && r_in_valid;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    lpfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lpfd_frame_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_echo_byte     = r_out.echo_byte;
    assign o_byte_kind     = r_out.byte_kind;
    assign o_frame_offset  = r_out.frame_offset;
    assign o_payload_count = r_out.payload_count;
    assign o_frame_end     = r_out.frame_end;

`ifndef SYNTHESIS
    a_end_on_crc_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.frame_end == (r_out.byte_kind == lpfd_pkg::KIND_CRC_HI)))
        else $error("frame end flag does not match crc high tag");

    a_skip_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.byte_kind == lpfd_pkg::KIND_SKIP
            || r_out.byte_kind == lpfd_pkg::KIND_SYNC1)) |-> (r_out.frame_offset == '0))
        else $error("hunt byte tagged away from frame start");

    a_held_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("waiting input request lost or overwritten");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed request did not reach the result register");
`endif

endmodule
